// ===== rtl/positional_array_list_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the positional array list core
// Clocked property checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define PAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PAL_ASSERT(lbl, prop, msg)
`define PAL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/pal_pkg.sv =====
// ---------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list core.
// ---------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int PosW     = 5;
  localparam int CmdW     = 3;
  localparam int StatW    = 2;
  localparam int WordW    = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_READ      = 3'd0,
    CMD_OVERWRITE = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPLY
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // carry out the captured command
  } ctrl_cmd_t;

  // Datapath to top level
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/pal_ctrl.sv =====
// ---------------------------------------------------------------------------
// pal_ctrl
// Sequencer: capture, execute, reply.
// ---------------------------------------------------------------------------
`default_nettype none

module pal_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output pal_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import pal_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) state_d = S_EXEC;
      S_EXEC:  state_d = S_REPLY;
      S_REPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_EXEC:  cmd_o.exec = 1'b1;
      S_REPLY: done_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pal_datapath.sv =====
// ---------------------------------------------------------------------------
// pal_datapath
// Entry register array with positional shift, count and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module pal_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pal_pkg::ctrl_cmd_t                  cmd_i,
  input  wire logic [pal_pkg::CmdW-1:0]            command_i,
  input  wire logic [pal_pkg::PosW-1:0]            position_i,
  input  wire logic signed [pal_pkg::WordW-1:0]    value_i,
  output logic [pal_pkg::StatW-1:0]                status_o,
  output logic signed [pal_pkg::WordW-1:0]         data_o,
  output logic [pal_pkg::CntW-1:0]                 count_o,
  output pal_pkg::dp_status_t                      stat_o
);
  import pal_pkg::*;

  logic [CmdW-1:0]          cmd_q;
  logic [PosW-1:0]          pos_q;
  logic signed [WordW-1:0]  val_q;

  logic signed [WordW-1:0]  entries_q [Capacity];
  logic signed [WordW-1:0]  entries_d [Capacity];
  logic [CntW-1:0]          count_q, count_d;
  logic [StatW-1:0]         status_q, status_d;
  logic signed [WordW-1:0]  data_q, data_d;

  logic [PosW-1:0]          pos_m1;
  logic [IdxW-1:0]          idx;
  logic                     in_range;
  logic                     ins_range;
  logic                     is_full;
  logic                     is_empty;
  logic signed [WordW-1:0]  rd_word;

  assign pos_m1    = pos_q - PosW'(1);
  assign idx       = pos_m1[IdxW-1:0];
  assign in_range  = (pos_q != '0) && (pos_q <= count_q);
  assign ins_range = (pos_q != '0) && ({1'b0, pos_q} <= ({1'b0, count_q} + (CntW+1)'(1)));
  assign is_full   = (count_q == CntW'(Capacity));
  assign is_empty  = (count_q == '0);
  assign rd_word   = entries_q[idx];

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    status_d  = STAT_OK;
    data_d    = '0;
    unique case (cmd_e'(cmd_q))
      CMD_READ: begin
        if (in_range) data_d = rd_word;
        else begin
          status_d = STAT_BADPOS;
          data_d   = '1;
        end
      end
      CMD_OVERWRITE: begin
        if (in_range) entries_d[idx] = val_q;
        else status_d = STAT_BADPOS;
      end
      CMD_INSERT: begin
        if (is_full) status_d = STAT_FULL;
        else if (!ins_range) status_d = STAT_BADPOS;
        else begin
          // shift everything from the position upwards by one
          for (int i = 1; i < Capacity; i++) begin
            if (IdxW'(i) > idx) entries_d[i] = entries_q[i-1];
          end
          entries_d[idx] = val_q;
          count_d        = count_q + CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (is_empty) status_d = STAT_EMPTY;
        else if (!in_range) status_d = STAT_BADPOS;
        else begin
          data_d = rd_word;
          for (int i = 0; i < Capacity - 1; i++) begin
            if (IdxW'(i) >= idx) entries_d[i] = entries_q[i+1];
          end
          count_d = count_q - CntW'(1);
        end
      end
      CMD_CLEAR: count_d = '0;
      default: status_d = STAT_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.exec) begin
      entries_q <= entries_d;
      status_q  <= status_d;
      data_q    <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign status_o     = status_q;
  assign data_o       = data_q;
  assign count_o      = count_q;
  assign stat_o.empty = is_empty;
  assign stat_o.full  = is_full;

endmodule

`default_nettype wire

// ===== rtl/positional_array_list_core.sv =====
// ---------------------------------------------------------------------------
// positional_array_list_core
// Bounded ordered list of 16 signed words with positional access.
// ---------------------------------------------------------------------------
// Usage:
//   Drive command_i, position_i (1-based) and value_i and raise start_i; the
//   transaction is taken at a rising edge where start_i is high and busy_o
//   is low. Commands: read, overwrite, insert, remove, clear.
//   Each transaction gives exactly one result: done_o is high for one cycle
//   with status_o, data_o, count_o, is_empty_o and is_full_o valid. The
//   receiver cannot stall and must take the result in that cycle.
// Sequence:
//   The accept edge moves the controller to execute, where the datapath
//   registers the result, and then to reply, where done_o presents it.
//   busy_o stays high through execute and reply, so no new transaction is
//   taken until the reply is over, as set by the capture / execute / reply
//   sequence of the controller. Insert and remove shift the whole register
//   array in the execute cycle, comparing each entry's index with the position.
// Reset:
//   rst_ni (asynchronous, active low) empties the list and idles the
//   controller. Entry contents are left as they are and are never read
//   before an insert has written them.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_array_list_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [pal_pkg::CmdW-1:0]           command_i,
  input  wire logic [pal_pkg::PosW-1:0]           position_i,
  input  wire logic signed [pal_pkg::WordW-1:0]   value_i,
  output logic                                    done_o,
  output logic [pal_pkg::StatW-1:0]               status_o,
  output logic signed [pal_pkg::WordW-1:0]        data_o,
  output logic [pal_pkg::CntW-1:0]                count_o,
  output logic                                    is_empty_o,
  output logic                                    is_full_o
);
  import pal_pkg::*;

  `include "positional_array_list_core_assert.svh"

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_stat;

  // Sequence each transaction: capture, execute, reply
  pal_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_o   (ctrl_cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Hold the entries and count, and register the result
  pal_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctrl_cmd),
    .command_i  (command_i),
    .position_i (position_i),
    .value_i    (value_i),
    .status_o   (status_o),
    .data_o     (data_o),
    .count_o    (count_o),
    .stat_o     (dp_stat)
  );

  // Flags follow the count that the result reports
  assign is_empty_o = dp_stat.empty;
  assign is_full_o  = dp_stat.full;

  // A taken transaction moves straight to execute, never to reply
  `PAL_ASSERT(a_accept_exec, (start_i && !busy_o) |=> (busy_o && !done_o), "accept did not start execute")
  // After the reply the core is free again
  `PAL_ASSERT(a_reply_free, done_o |=> !busy_o, "core still busy after reply")
  // A reply always follows an execute cycle
  `PAL_ASSERT(a_reply_after_exec, done_o |-> $past(busy_o && !done_o), "reply without execute")
  // The count never exceeds the capacity
  `PAL_ASSERT_ALWAYS(a_count_bound, count_o <= CntW'(Capacity), "count above capacity")

endmodule

`default_nettype wire

// ===== sim/positional_array_list_core_checker.sv =====
// ---------------------------------------------------------------------------
// Positional array list reply checker
// Watches the command and reply channels of the list core, predicts every
// reply from its own copy of the list and compares each field.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_array_list_core_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic                             busy_i,
  input  wire logic [pal_pkg::CmdW-1:0]         command_i,
  input  wire logic [pal_pkg::PosW-1:0]         position_i,
  input  wire logic signed [pal_pkg::WordW-1:0] value_i,
  input  wire logic                             done_i,
  input  wire logic [pal_pkg::StatW-1:0]        status_i,
  input  wire logic signed [pal_pkg::WordW-1:0] data_i,
  input  wire logic [pal_pkg::CntW-1:0]         count_i,
  input  wire logic                             is_empty_i,
  input  wire logic                             is_full_i,
  output int                                    mismatch_count_o,
  output int                                    pending_o
);
  import pal_pkg::*;

  typedef struct {
    stat_e                    status;
    logic signed [WordW-1:0]  data;
    logic [CntW-1:0]          count;
    logic                     empty;
    logic                     full;
  } list_reply_t;

  logic signed [WordW-1:0] shadow_words [Capacity];
  int unsigned             shadow_fill = 0;
  list_reply_t             awaited_replies [$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  // Carry out one command on the shadow list and return its reply.
  function automatic list_reply_t apply_list_command(logic [CmdW-1:0] cmd,
                                                     int unsigned pos,
                                                     logic signed [WordW-1:0] val);
    list_reply_t r;
    int          i;
    r.status = STAT_OK;
    r.data   = '0;
    case (cmd_e'(cmd))
      CMD_READ: begin
        if (pos < 1 || pos > shadow_fill) begin
          r.status = STAT_BADPOS;
          r.data   = -1;
        end else begin
          r.data = shadow_words[pos-1];
        end
      end
      CMD_OVERWRITE: begin
        if (pos < 1 || pos > shadow_fill) r.status = STAT_BADPOS;
        else shadow_words[pos-1] = val;
      end
      CMD_INSERT: begin
        // full wins over a bad position
        if (shadow_fill >= Capacity) begin
          r.status = STAT_FULL;
        end else if (pos < 1 || pos > shadow_fill + 1) begin
          r.status = STAT_BADPOS;
        end else begin
          for (i = shadow_fill; i >= int'(pos); i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos-1] = val;
          shadow_fill++;
        end
      end
      CMD_REMOVE: begin
        // empty wins over a bad position
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else if (pos < 1 || pos > shadow_fill) begin
          r.status = STAT_BADPOS;
        end else begin
          r.data = shadow_words[pos-1];
          for (i = pos - 1; i + 1 < int'(shadow_fill); i++) shadow_words[i] = shadow_words[i+1];
          shadow_fill--;
        end
      end
      CMD_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    r.count = CntW'(shadow_fill);
    r.empty = (shadow_fill == 0);
    r.full  = (shadow_fill == Capacity);
    return r;
  endfunction

  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni) begin
      // compare first: a reply at this edge belongs to an earlier transaction
      if (done_i) begin
        if (awaited_replies.size() == 0) begin
          $error("reply with no transaction outstanding");
          mismatch_count_o++;
        end else begin
          want = awaited_replies.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatch_count_o++;
          end
          if (data_i !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, data_i);
            mismatch_count_o++;
          end
          if (count_i !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count_i);
            mismatch_count_o++;
          end
          if (is_empty_i !== want.empty) begin
            $error("is_empty: expected %0b, got %0b", want.empty, is_empty_i);
            mismatch_count_o++;
          end
          if (is_full_i !== want.full) begin
            $error("is_full: expected %0b, got %0b", want.full, is_full_i);
            mismatch_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        awaited_replies.push_back(apply_list_command(command_i, position_i, value_i));
      end
      pending_o = awaited_replies.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/positional_array_list_core_tb.sv =====
// ---------------------------------------------------------------------------
// Positional array list core testbench
// Drives directed and random list commands into the core with random
// hold-offs; a checker beside the core predicts and compares every reply.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_array_list_core_tb;
  import pal_pkg::*;

  // Command codes the core must treat as no-ops
  localparam logic [CmdW-1:0] CmdSpare0 = 3'd5;
  localparam logic [CmdW-1:0] CmdSpare1 = 3'd6;
  localparam logic [CmdW-1:0] CmdSpare2 = 3'd7;

  localparam int RandomItems = 400;
  localparam int EpochLen    = 40;   // items per grow or shrink epoch
  localparam int IdlePct     = 38;   // chance of a hold-off cycle, per cycle

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [CmdW-1:0]         command_i;
  logic [PosW-1:0]         position_i;
  logic signed [WordW-1:0] value_i;
  logic                    done_o;
  logic [StatW-1:0]        status_o;
  logic signed [WordW-1:0] data_o;
  logic [CntW-1:0]         count_o;
  logic                    is_empty_o;
  logic                    is_full_o;

  int mismatch_count;
  int pending_replies;

  // Rough fill level of the list, kept only to aim positions at valid slots
  int fill_guess;
  bit hold_offs_on;

  positional_array_list_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .command_i  (command_i),
    .position_i (position_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .data_o     (data_o),
    .count_o    (count_o),
    .is_empty_o (is_empty_o),
    .is_full_o  (is_full_o)
  );

  positional_array_list_core_checker reply_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .command_i        (command_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .done_i           (done_o),
    .status_i         (status_o),
    .data_i           (data_o),
    .count_i          (count_o),
    .is_empty_i       (is_empty_o),
    .is_full_i        (is_full_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_replies)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the core stops answering.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // Present one transaction at the falling edge and hold it until the core
  // takes it; return at the next falling edge with nothing yet driven there.
  task automatic issue_command(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] pos,
                               input logic signed [WordW-1:0] val);
    start_i    <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy_o);
    // track the fill level the same way the list does, loosely
    case (cmd)
      CMD_INSERT: if (fill_guess < Capacity && pos >= 1 && pos <= fill_guess + 1) fill_guess++;
      CMD_REMOVE: if (fill_guess > 0 && pos >= 1 && pos <= fill_guess) fill_guess--;
      CMD_CLEAR:  fill_guess = 0;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Drop start for one cycle, with noise on the command bus.
  task automatic hold_off_cycle();
    start_i    <= 1'b0;
    command_i  <= CmdW'($urandom);
    position_i <= PosW'($urandom);
    value_i    <= $urandom;
    @(negedge clk_i);
  endtask

  task automatic random_hold_offs();
    while (hold_offs_on && $urandom_range(99) < IdlePct) hold_off_cycle();
  endtask

  // Hold the sender until every outstanding reply has come back.
  task automatic drain_replies();
    hold_off_cycle();
    while (pending_replies != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [WordW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a valid slot for the command, sometimes zero or anything at all.
  function automatic logic [PosW-1:0] pick_position(logic [CmdW-1:0] cmd);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return PosW'($urandom_range(31));
    if (cmd == CMD_INSERT) return PosW'($urandom_range(fill_guess + 1, 1));
    return PosW'((fill_guess == 0) ? 1 : $urandom_range(fill_guess, 1));
  endfunction

  // Grow epochs lean on insert so the list fills up; shrink epochs lean on
  // remove so it drains to empty and beyond.
  function automatic logic [CmdW-1:0] pick_command(bit growing);
    int r;
    r = $urandom_range(99);
    if (r < 60) return growing ? CMD_INSERT : CMD_REMOVE;
    if (r < 68) return growing ? CMD_REMOVE : CMD_INSERT;
    if (r < 80) return CMD_READ;
    if (r < 92) return CMD_OVERWRITE;
    if (r < 94) return CMD_CLEAR;
    if (r < 96) return CmdSpare0;
    if (r < 98) return CmdSpare1;
    return CmdSpare2;
  endfunction

  initial begin
    logic [CmdW-1:0] cmd;
    // known values on every input from time zero
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    command_i    = '0;
    position_i   = '0;
    value_i      = '0;
    fill_guess   = 0;
    hold_offs_on = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-list cases first
    issue_command(CMD_READ,      5'd0, 32'sd0);          // position zero
    issue_command(CMD_READ,      5'd1, 32'sd0);          // read of empty list
    issue_command(CMD_REMOVE,    5'd1, 32'sd0);          // remove from empty list
    issue_command(CMD_OVERWRITE, 5'd1, 32'sd5);          // overwrite out of range
    issue_command(CMD_INSERT,    5'd0, 32'sd9);          // insert at zero
    issue_command(CMD_INSERT,    5'd2, 32'sd9);          // insert past the end
    // build [-1, min, max] at the extremes of the word
    issue_command(CMD_INSERT,    5'd1, 32'sh8000_0000);
    random_hold_offs();
    issue_command(CMD_INSERT,    5'd2, 32'sh7FFF_FFFF);
    issue_command(CMD_INSERT,    5'd1, -32'sd1);
    issue_command(CMD_READ,      5'd1, 32'sd0);
    issue_command(CMD_READ,      5'd3, 32'sd0);
    issue_command(CMD_READ,      5'd4, 32'sd0);          // one past the count
    issue_command(CMD_READ,      5'd31, 32'sd0);         // top of the position field
    random_hold_offs();
    issue_command(CMD_OVERWRITE, 5'd3, 32'sd0);
    issue_command(CMD_OVERWRITE, 5'd0, 32'sd1);
    issue_command(CMD_REMOVE,    5'd2, 32'sd0);          // take the minimum out
    issue_command(CMD_REMOVE,    5'd3, 32'sd0);          // past the count
    issue_command(CMD_REMOVE,    5'd0, 32'sd0);
    // unused codes: no change, plain status
    issue_command(CmdSpare0,     5'd31, -32'sd1);
    issue_command(CmdSpare1,     5'd17, 32'sd0);
    issue_command(CmdSpare2,     5'd1, 32'sh5555_5555);
    issue_command(CMD_CLEAR,     5'd0, 32'sd0);
    issue_command(CMD_READ,      5'd1, 32'sd0);          // read after clear
    issue_command(CMD_INSERT,    5'd1, 32'sh5555_5555);
    issue_command(CMD_INSERT,    5'd3, 32'shAAAA_AAAA);  // two past the count

    drain_replies();

    // Random: alternate grow and shrink epochs, with one run of back-to-back
    // transactions and one full drain part-way through.
    for (int n = 0; n < RandomItems; n++) begin
      hold_offs_on = !(n >= 200 && n < 280);
      if (n == 300) drain_replies();
      cmd = pick_command(((n / EpochLen) % 2) == 0);
      issue_command(cmd, pick_position(cmd), pick_word());
      random_hold_offs();
    end

    drain_replies();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/pal_pkg.sv
rtl/pal_ctrl.sv
rtl/pal_datapath.sv
rtl/positional_array_list_core.sv
sim/positional_array_list_core_checker.sv
sim/positional_array_list_core_tb.sv
